FILE: rtl/lfsa_pkg.sv
// Package for the lowest-free slot allocator: command and status codes,
// bitmap word geometry and the sequencer state type.
// No dependencies; imported by the allocator, lfsa_scan and the testbench (lfsa_ram does not use it).
package lfsa_pkg;

    // bitmap words held in the RAM
    localparam int WORD_BITS  = 32;
    localparam int WORD_IDX_W = 5;

    // request kinds (tuser on the request side)
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result kinds (tuser on the result side)
    localparam logic [1:0] ST_GRANT    = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

FILE: rtl/lowest_free_slot_allocator.sv
// Lowest-free slot allocator: bitmap in RAM, pointer to lowest free slot.
// Depends on lfsa_pkg, lfsa_ram and lfsa_scan.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid / tready            tuser command, tdata slot_in
//  m_axis    out  tvalid / tready            tuser status,  tdata slot_out
//
// Release: read the bitmap word, then write it back. Allocate: read the
// granted slot's 32-bit word and write it back; when the next free slot
// lies beyond that word, further words are read from the bitmap RAM. Pool
// full and out-of-range releases need no RAM access. Reset is synchronous;
// per-word valid flops stand in for a cleared bitmap; no clearing pass is needed.
// A stalled result sits in the output register while the next request is
// taken; that request waits only when its own result is ready to go out.
module lowest_free_slot_allocator #(
    parameter int POOL_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [5:0] slot_in, [7:6] zero
    input  logic       i_s_axis_tuser,   // [0] command
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [5:0] slot_out, [7:6] zero
    output logic [1:0] o_m_axis_tuser    // [1:0] status
);
    import lfsa_pkg::*;

    localparam int NUM_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PTR_W     = $clog2(POOL_SLOTS + 1);
    localparam int XW        = (PTR_W > 7) ? PTR_W : 7;
    localparam int TAIL      = POOL_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] TAIL_PAD =
        WORD_BITS'(~((64'd1 << TAIL) - 64'd1));
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
    localparam logic [PTR_W-1:0]   PTR_FULL  = PTR_W'(POOL_SLOTS);

    // registers
    t_state                r_state, n_state;
    logic [PTR_W-1:0]      r_lowest, n_lowest;
    logic [WADDR_W-1:0]    r_word, n_word;
    logic [WORD_IDX_W-1:0] r_bit, n_bit;
    logic                  r_is_rel, n_is_rel;
    logic [1:0]            r_res_status, n_res_status;
    logic [5:0]            r_res_slot, n_res_slot;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_status, n_out_status;
    logic [5:0]            r_out_slot, n_out_slot;
    logic [NUM_WORDS-1:0]  r_row_valid;
    logic                  r_rd_valid;

    // RAM and finder connections
    logic                  ram_we, ram_re;
    logic [WADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
    logic [WORD_BITS-1:0]  rd_word, bit_mask, mod_word, scan_in;
    logic [WORD_IDX_W-1:0] scan_start, hit_bit;
    logic                  hit;
    logic [PTR_W-1:0]      hit_ptr;

    logic                  accept, fin, out_free, full, slot_ok;
    logic [XW-1:0]         lf_x, slot_x;

    lfsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfsa_scan u_scan (
        .i_word  (scan_in),
        .i_start (scan_start),
        .o_found (hit),
        .o_bit   (hit_bit)
    );

    // handshake and decode
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign lf_x            = XW'(r_lowest);
    assign slot_x          = XW'(i_s_axis_tdata[5:0]);
    assign slot_ok         = slot_x < XW'(POOL_SLOTS);
    assign full            = (r_lowest == PTR_FULL);

    // word under modification; a never-written word reads as all free
    assign rd_word    = r_rd_valid ? ram_rdata : '0;
    assign bit_mask   = WORD_BITS'(1) << r_bit;
    assign mod_word   = r_is_rel ? (rd_word & ~bit_mask) : (rd_word | bit_mask);
    assign ram_wdata  = mod_word;
    assign scan_in    = ((r_state == S_MOD) ? mod_word : rd_word) |
                        ((r_word == LAST_WORD) ? TAIL_PAD : '0);
    assign scan_start = (r_state == S_MOD) ? r_bit : '0;
    assign hit_ptr    = PTR_W'((XW'(r_word) << WORD_IDX_W) | XW'(hit_bit));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_lowest     = r_lowest;
        n_word       = r_word;
        n_bit        = r_bit;
        n_is_rel     = r_is_rel;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_word;
        fin          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == CMD_RELEASE) begin
                        n_res_status = ST_RELEASED;
                        n_res_slot   = i_s_axis_tdata[5:0];
                        if (slot_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = WADDR_W'(slot_x >> WORD_IDX_W);
                            n_word    = WADDR_W'(slot_x >> WORD_IDX_W);
                            n_bit     = slot_x[WORD_IDX_W-1:0];
                            n_is_rel  = 1'b1;
                            n_state   = S_MOD;
                            if (slot_x < lf_x) begin
                                n_lowest = PTR_W'(slot_x);
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end else if (full) begin
                        n_res_status = ST_FULL;
                        n_res_slot   = '0;
                        fin          = 1'b1;
                    end else begin
                        n_res_status = ST_GRANT;
                        n_res_slot   = lf_x[5:0];
                        ram_re       = 1'b1;
                        ram_raddr    = WADDR_W'(lf_x >> WORD_IDX_W);
                        n_word       = WADDR_W'(lf_x >> WORD_IDX_W);
                        n_bit        = lf_x[WORD_IDX_W-1:0];
                        n_is_rel     = 1'b0;
                        n_state      = S_MOD;
                    end
                end
            end
            S_MOD, S_SCAN: begin
                // write back the modified word on the first pass only
                ram_we = (r_state == S_MOD);
                if ((r_state == S_MOD) && r_is_rel) begin
                    fin = 1'b1;
                end else if (hit) begin
                    n_lowest = hit_ptr;
                    fin      = 1'b1;
                end else if (r_word == LAST_WORD) begin
                    n_lowest = PTR_FULL;
                    fin      = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_word + WADDR_W'(1);
                    n_word    = r_word + WADDR_W'(1);
                    n_state   = S_SCAN;
                end
            end
            S_DONE: begin
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result register
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = n_res_status;
                n_out_slot   = n_res_slot;
                n_state      = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lowest    <= '0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lowest    <= n_lowest;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_row_valid[r_word] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_valid <= r_row_valid[ram_raddr];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_is_rel     <= n_is_rel;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

endmodule

FILE: rtl/lfsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the slot bitmap of the allocator.
module lfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lfsa_scan.sv
// Free-bit finder for one bitmap word: lowest clear bit at or above a start.
// Depends on lfsa_pkg for the word geometry.
module lfsa_scan (
    input  logic [lfsa_pkg::WORD_BITS-1:0]  i_word,
    input  logic [lfsa_pkg::WORD_IDX_W-1:0] i_start,
    output logic                            o_found,
    output logic [lfsa_pkg::WORD_IDX_W-1:0] o_bit
);
    import lfsa_pkg::*;

    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] lowest_zero;

    // bits below the start count as used
    assign low_mask = WORD_BITS'((33'd1 << i_start) - 33'd1);
    assign masked   = i_word | low_mask;

    // isolate the lowest clear bit with one add
    assign lowest_zero = ~masked & (masked + WORD_BITS'(1));
    assign o_found     = ~&masked;

    // one-hot to index
    always_comb begin
        o_bit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest_zero[i]) begin
                o_bit = o_bit | WORD_IDX_W'(i);
            end
        end
    end

endmodule

FILE: test/tb.sv
// Testbench for lowest_free_slot_allocator: random allocate/release traffic
// checked against an in-bench model of the slot bitmap and lowest-free pointer.
// Depends on lfsa_pkg and the allocator RTL.
module tb;
    import lfsa_pkg::*;

    localparam int SLOTS       = 64;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_STALL  = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic       cmd;
        logic [5:0] slot;
    } t_request;

    typedef struct {
        logic [1:0] status;
        logic [5:0] slot;
    } t_reply;

    // DUT ports
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'd0;   // [5:0] slot_in, [7:6] zero
    logic       i_s_axis_tuser = 1'b0;   // [0] command
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [5:0] slot_out, [7:6] zero
    logic [1:0] o_m_axis_tuser;          // [1:0] status

    // pending requests, replies still owed, pool model
    t_request   pending[$];
    t_reply     replies_due[$];
    bit         slot_taken[SLOTS];
    int         first_free = 0;

    t_idle_mode idle_mode = IDLE_NONE;
    int         stall_orders = 0;
    int         stall_seen = 0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    int         fault_count = 0;

    lowest_free_slot_allocator #(
        .POOL_SLOTS(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the pool model and return the reply it owes
    function automatic t_reply pool_reply(t_request req);
        t_reply rep;
        int     grant;
        if (req.cmd == CMD_ALLOC) begin
            if (first_free >= SLOTS) begin
                rep.status = ST_FULL;
                rep.slot   = 6'd0;
            end else begin
                grant             = first_free;
                slot_taken[grant] = 1'b1;
                while (first_free < SLOTS && slot_taken[first_free])
                    first_free++;
                rep.status = ST_GRANT;
                rep.slot   = grant[5:0];
            end
        end else begin
            // releasing a free slot is harmless; pointer only moves down
            if (int'(req.slot) < SLOTS) begin
                slot_taken[req.slot] = 1'b0;
                if (int'(req.slot) < first_free)
                    first_free = req.slot;
            end
            rep.status = ST_RELEASED;
            rep.slot   = req.slot;
        end
        return rep;
    endfunction

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 61;
            IDLE_BOTH: return $urandom_range(0, 99) < 36;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 61;
            IDLE_BOTH: return $urandom_range(0, 99) < 36;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic queue_request(logic cmd, logic [5:0] slot);
        t_request req;
        req.cmd  = cmd;
        req.slot = slot;
        pending.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: predict on acceptance, then offer the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                replies_due.push_back(pool_reply(pending[0]));
                void'(pending.pop_front());
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending.size() != 0 && !sender_gap()) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {2'b00, pending[0].slot};
                    i_s_axis_tuser  <= pending[0].cmd;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor and receiver backpressure
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: status %0d slot_out %0d",
                           o_m_axis_tuser, o_m_axis_tdata);
                    fault_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                        fault_count++;
                    end
                    if (o_m_axis_tdata !== {2'b00, want.slot}) begin
                        $error("slot_out: expected %0d, got %0d", want.slot, o_m_axis_tdata);
                        fault_count++;
                    end
                end
            end
            // a new stall order starts a long hold-off
            if (stall_orders != stall_seen) begin
                stall_seen      <= stall_orders;
                stall_left      <= LONG_STALL;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left      <= stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !receiver_gap();
            end
        end
    end

    // Watchdog: cycles without any handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int alloc_pct[6];
        int pct;
        alloc_pct = '{100, 70, 15, 55, 90, 5};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: grants from zero, release of used and free slots,
        // pointer moving back down, extremes of slot_in
        queue_request(CMD_ALLOC, 6'd63);
        queue_request(CMD_ALLOC, 6'd0);
        queue_request(CMD_ALLOC, 6'd42);
        queue_request(CMD_ALLOC, 6'd21);
        queue_request(CMD_RELEASE, 6'd2);
        queue_request(CMD_RELEASE, 6'd2);
        queue_request(CMD_RELEASE, 6'd63);
        queue_request(CMD_ALLOC, 6'd0);
        queue_request(CMD_ALLOC, 6'd0);
        queue_request(CMD_RELEASE, 6'd0);
        queue_request(CMD_RELEASE, 6'd3);
        queue_request(CMD_ALLOC, 6'd63);
        queue_request(CMD_ALLOC, 6'd63);
        queue_request(CMD_RELEASE, 6'd63);
        queue_request(CMD_RELEASE, 6'd0);
        queue_request(CMD_ALLOC, 6'd0);
        wait_drained();

        // random phases; allocation-heavy ones run the pool into full,
        // release-heavy ones empty it again
        for (int p = 0; p < PHASES; p++) begin
            idle_mode = t_idle_mode'(p % 4);
            pct       = alloc_pct[p % 6];
            if (p == 4)
                stall_orders++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 1))
                    queue_request($urandom_range(0, 99) < pct ? CMD_ALLOC : CMD_RELEASE,
                                  6'($urandom_range(0, 63)));
                else
                    queue_request($urandom_range(0, 99) < pct ? CMD_ALLOC : CMD_RELEASE,
                                  6'($urandom_range(0, 11)));
            end
            // sender holds back until every reply of the phase is in
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d replies never arrived", replies_due.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
